// ----- design/pfcs_pkg.sv -----
// pfcs_pkg: shared types, sizes and command codes of the flash command sequencer
// no dependencies; imported by pfcs_cmd, the top level and the testbench

package pfcs_pkg;

   // array size and derived widths
   localparam int FLASH_BYTES = 65536;
   localparam int ADDR_W      = $clog2(FLASH_BYTES);
   localparam int BUS_ADDR_W  = 16;

   localparam logic [BUS_ADDR_W:0] FLASH_LIMIT = (BUS_ADDR_W+1)'(FLASH_BYTES);
   localparam logic [ADDR_W-1:0]   SWEEP_LAST  = ADDR_W'(FLASH_BYTES - 1);

   typedef logic [ADDR_W-1:0] flash_addr_type;

   // access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // unlock addresses, compared on the low 14 address bits
   localparam logic [13:0] UNLOCK_ADDR1 = 14'h0AAA;
   localparam logic [13:0] UNLOCK_ADDR2 = 14'h0555;

   // bus data codes
   localparam logic [7:0] DATA_UNLOCK1    = 8'hAA;
   localparam logic [7:0] DATA_UNLOCK2    = 8'h55;
   localparam logic [7:0] DATA_ERASE      = 8'h80;
   localparam logic [7:0] DATA_AUTOSEL    = 8'h90;
   localparam logic [7:0] DATA_PROGRAM    = 8'hA0;
   localparam logic [7:0] DATA_CHIP_ERASE = 8'h10;
   localparam logic [7:0] DATA_SECT_ERASE = 8'h30;
   localparam logic [7:0] DATA_SUSPEND    = 8'hB0;
   localparam logic [7:0] DATA_RESET      = 8'hF0;

   // command state: high nibble = command, low nibble = cycle step
   localparam logic [7:0] CMD_IDLE    = 8'h00;
   localparam logic [7:0] CMD_UNLOCK1 = 8'h01;
   localparam logic [7:0] CMD_UNLOCK2 = 8'h02;
   localparam logic [7:0] CMD_AUTOSEL = 8'h90;
   localparam logic [3:0] CMD_HI_PROGRAM = 4'hA;
   localparam logic [3:0] CMD_HI_AUTOSEL = 4'h9;

   localparam logic [3:0] STEP_IDLE     = 4'd0;
   localparam logic [3:0] STEP_UNLOCK1  = 4'd1;
   localparam logic [3:0] STEP_UNLOCK2  = 4'd2;
   localparam logic [3:0] STEP_SELECT   = 4'd3;
   localparam logic [3:0] STEP_UNLOCK3  = 4'd4;
   localparam logic [3:0] STEP_CONFIRM  = 4'd5;

   // autoselect keys and ids
   localparam logic [11:0] KEY_MFR    = 12'h900;
   localparam logic [11:0] KEY_DEVICE = 12'h902;
   localparam logic [11:0] KEY_PROT   = 12'h904;
   localparam logic [7:0]  ID_MFR     = 8'h01;
   localparam logic [7:0]  ID_DEVICE  = 8'h23;
   localparam logic [7:0]  ID_PROT    = 8'h00;

   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   // one bus access
   typedef struct packed {
      logic                  kind;
      logic [BUS_ADDR_W-1:0] address;
      logic [7:0]            write_data;
   } req_item_type;

   // decision of the command decoder for one access
   typedef struct packed {
      logic [7:0] next_cmd;
      logic [7:0] read_data;
      logic       prog_we;
      logic [7:0] prog_data;
      logic       erase;
   } cmd_action_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_ERASE,
      ST_DONE
   } seq_state_type;

endpackage

// ----- design/pfcs_ram.sv -----
// pfcs_ram: generic single-port ram with registered read
// no dependencies

module pfcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read on one port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ----- design/pfcs_cmd.sv -----
// pfcs_cmd: command-sequence decoder for one bus access
// depends on pfcs_pkg

module pfcs_cmd import pfcs_pkg::*; (
   input  logic [7:0]     cmd_state,
   input  req_item_type   item,
   input  logic [7:0]     array_byte,
   input  logic           write_protect,
   input  logic           array_erased,
   output cmd_action_type action
);

   logic [13:0] a14;
   logic        in_range;
   logic [7:0]  st;
   logic [11:0] key;
   logic        id_hit;
   logic [7:0]  id_byte;
   logic [7:0]  wd;

   assign a14      = item.address[13:0];
   assign in_range = {1'b0, item.address} < FLASH_LIMIT;
   assign wd       = item.write_data;
   assign key      = {cmd_state[7:4], item.address[7:0]};

   always_comb begin
      action           = '0;
      action.next_cmd  = cmd_state;
      action.prog_data = wd & array_byte;
      id_hit           = 1'b0;
      id_byte          = ID_PROT;
      // autoselect state folds back to its base before stepping
      st = (cmd_state[7:4] == CMD_HI_AUTOSEL) ? CMD_AUTOSEL : cmd_state;

      if (item.kind == KIND_READ) begin
         // read ends any pending command, autoselect returns ids
         if (cmd_state != CMD_IDLE) begin
            action.next_cmd = CMD_IDLE;
            priority if (key == KEY_MFR) begin
               id_hit  = 1'b1;
               id_byte = ID_MFR;
            end else if (key == KEY_DEVICE) begin
               id_hit  = 1'b1;
               id_byte = ID_DEVICE;
            end else if (key == KEY_PROT) begin
               id_hit  = 1'b1;
               id_byte = ID_PROT;
            end else begin
               id_hit  = 1'b0;
            end
         end
         if (id_hit) begin
            action.read_data = id_byte;
         end else if (in_range) begin
            action.read_data = array_byte;
         end else begin
            action.read_data = ERASED_BYTE;
         end
      end else begin
         // write steps the unlock sequence
         action.next_cmd = CMD_IDLE;
         unique case (st[3:0])
            STEP_IDLE: begin
               if (wd != DATA_SUSPEND && wd != DATA_SECT_ERASE && wd != DATA_RESET &&
                   a14 == UNLOCK_ADDR1 && wd == DATA_UNLOCK1) begin
                  action.next_cmd = CMD_UNLOCK1;
               end
            end
            STEP_UNLOCK1: begin
               if (a14 == UNLOCK_ADDR2 && wd == DATA_UNLOCK2) begin
                  action.next_cmd = CMD_UNLOCK2;
               end
            end
            STEP_UNLOCK2: begin
               if (a14 == UNLOCK_ADDR1 &&
                   (wd == DATA_ERASE || wd == DATA_AUTOSEL || wd == DATA_PROGRAM)) begin
                  action.next_cmd = wd | {4'h0, STEP_SELECT};
               end
            end
            STEP_SELECT: begin
               if (st[7:4] == CMD_HI_PROGRAM) begin
                  // program only clears bits
                  if (!write_protect && in_range && action.prog_data != array_byte) begin
                     action.prog_we = 1'b1;
                  end
               end else if (a14 == UNLOCK_ADDR1 && wd == DATA_UNLOCK1) begin
                  action.next_cmd = st + 8'd1;
               end
            end
            STEP_UNLOCK3: begin
               if (a14 == UNLOCK_ADDR2 && wd == DATA_UNLOCK2) begin
                  action.next_cmd = st + 8'd1;
               end
            end
            STEP_CONFIRM: begin
               if (((a14 == UNLOCK_ADDR1 && wd == DATA_CHIP_ERASE) ||
                    wd == DATA_SECT_ERASE) && !(write_protect || array_erased)) begin
                  action.erase = 1'b1;
               end
            end
            default: begin
               action.next_cmd = CMD_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- design/parallel_flash_command_sequencer.sv -----
// parallel_flash_command_sequencer: byte-wide nor flash command interface
// depends on pfcs_pkg, pfcs_ram, pfcs_cmd
//
//   channel   direction   handshake                  payload
//   req_      in          req_valid / req_stall      req_kind, req_address, req_write_data
//   rsp_      out         rsp_valid / rsp_stall      rsp_read_data, rsp_modified
//   csr_      in          csr_write_enable           csr_write_data (write protect)
//
// read, write and program: array read on transfer, decode and write-back next.
// an erase sweeps the array ram one byte a cycle.
// after reset a clearing pass fills the whole ram with ff; req_stall stays high meanwhile.
// a new item is taken while the last result waits; a second result waits in the sequencer.

module parallel_flash_command_sequencer import pfcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [BUS_ADDR_W-1:0] req_address,
   input  logic [7:0]            req_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_read_data,
   output logic                  rsp_modified,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   seq_state_type  state_ff, state_in;
   flash_addr_type cnt_ff, cnt_in;
   req_item_type   item_ff, item_in;
   logic [7:0]     cmd_ff, cmd_in;
   logic           erased_ff, erased_in;
   logic           changed_ff, changed_in;
   logic           wp_ff;
   logic [7:0]     pend_data_ff, pend_data_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic           rsp_mod_ff, rsp_mod_in;

   logic           sweep;
   logic           out_free;
   logic           load_out;
   logic [7:0]     out_data;
   flash_addr_type ram_addr;
   logic           ram_we;
   logic [7:0]     ram_wdata;
   logic [7:0]     ram_rdata;
   cmd_action_type action;

   // array storage
   pfcs_ram #(
      .WIDTH (8),
      .DEPTH (FLASH_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // command decoder
   pfcs_cmd u_cmd (
      .cmd_state     (cmd_ff),
      .item          (item_ff),
      .array_byte    (ram_rdata),
      .write_protect (wp_ff),
      .array_erased  (erased_ff),
      .action        (action)
   );

   // ram port selection
   assign sweep    = (state_ff == ST_CLEAR) || (state_ff == ST_ERASE);
   assign ram_we   = sweep || ((state_ff == ST_EXEC) && action.prog_we);
   assign ram_wdata = sweep ? ERASED_BYTE : action.prog_data;

   always_comb begin
      priority if (sweep) begin
         ram_addr = cnt_ff;
      end else if (state_ff == ST_IDLE) begin
         ram_addr = req_address[ADDR_W-1:0];
      end else begin
         ram_addr = item_ff.address[ADDR_W-1:0];
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      cmd_in       = cmd_ff;
      erased_in    = erased_ff;
      changed_in   = changed_ff;
      pend_data_in = pend_data_ff;
      load_out     = 1'b0;
      out_data     = pend_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == SWEEP_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in.kind       = req_kind;
               item_in.address    = req_address;
               item_in.write_data = req_write_data;
               state_in           = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd_in = action.next_cmd;
            if (action.prog_we) begin
               changed_in = 1'b1;
               erased_in  = 1'b0;
            end
            if (action.erase) begin
               changed_in   = 1'b1;
               erased_in    = 1'b1;
               pend_data_in = action.read_data;
               cnt_in       = '0;
               state_in     = ST_ERASE;
            end else if (out_free) begin
               load_out = 1'b1;
               out_data = action.read_data;
               state_in = ST_IDLE;
            end else begin
               pend_data_in = action.read_data;
               state_in     = ST_DONE;
            end
         end
         ST_ERASE: begin
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == SWEEP_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = load_out ? out_data : rsp_data_ff;
      rsp_mod_in   = load_out ? changed_in : rsp_mod_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         cmd_ff       <= CMD_IDLE;
         erased_ff    <= 1'b1;
         changed_ff   <= 1'b0;
         wp_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cmd_ff       <= cmd_in;
         erased_ff    <= erased_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            wp_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_mod_ff   <= rsp_mod_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_modified  = rsp_mod_ff;

endmodule

// ----- design/pfcs_chk.sv -----
// pfcs_chk: port-level checks of the flash command sequencer, bound to the top level
// depends on parallel_flash_command_sequencer ports only

module pfcs_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_modified
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pend_ff;
   logic       seen_mod_ff;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // items taken but not yet delivered, and sticky modified tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         seen_mod_ff <= 1'b0;
      end else begin
         pend_ff <= pend_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};
         if (rsp_xfer && rsp_modified) begin
            seen_mod_ff <= 1'b1;
         end
      end
   end

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_modified))
      else $error("stalled result changed");

   // every result belongs to an accepted item
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without a pending item");

   // at most two items in flight
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many items in flight");

   // modified flag is sticky
   a_mod_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_mod_ff |-> rsp_modified)
      else $error("modified flag dropped");

endmodule

bind parallel_flash_command_sequencer pfcs_chk u_pfcs_chk (.*);

// ----- tb/tb_parallel_flash_command_sequencer.sv -----
// tb_parallel_flash_command_sequencer: self-checking testbench of the flash command sequencer
// depends on pfcs_pkg and parallel_flash_command_sequencer; predicts every reply in-line
// directed unlock, program, autoselect and erase cases, then random command traffic

`timescale 1ns / 1ps

module tb_parallel_flash_command_sequencer;
   import pfcs_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int POOL_SIZE   = 16;

   typedef struct packed {
      logic [7:0] read_data;
      logic       modified;
   } flash_reply_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [BUS_ADDR_W-1:0] req_address;
   logic [7:0]            req_write_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [7:0]            rsp_read_data;
   logic                  rsp_modified;
   logic                  csr_write_enable;
   logic                  csr_write_data;

   // shadow of the flash and its command state
   logic [7:0]            flash_image [FLASH_BYTES];
   logic [7:0]            cmd_state;
   logic                  image_erased;
   logic                  image_changed;
   logic                  protect_on;

   flash_reply_type       awaited_replies [$];
   logic [15:0]           address_pool [POOL_SIZE];

   int                    sender_idle_pct;
   int                    receiver_stall_pct;
   int                    erase_allowance;
   int                    items_sent;
   int                    mismatch_count;
   int                    cycle_count;

   parallel_flash_command_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_modified     (rsp_modified),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                  awaited_replies.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t ns mismatch %s: got %h expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // compare each reply transfer with the oldest prediction
   always @(posedge clock) begin : reply_check
      flash_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("reply with none awaited", rsp_read_data, 8'h00);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_modified !== want.modified)
               report_mismatch("modified", {7'd0, rsp_modified}, {7'd0, want.modified});
         end
      end
   end

   // one bus access applied to the shadow flash; returns the byte read back
   task automatic emulate_access(input logic kind, input logic [15:0] addr,
                                 input logic [7:0] data, output logic [7:0] reply_byte);
      logic [13:0] low_addr;
      logic [11:0] id_key;
      logic [7:0]  programmed;
      logic        in_array;
      reply_byte = 8'h00;
      low_addr   = addr[13:0];
      in_array   = (32'(addr) < FLASH_BYTES);
      if (kind == KIND_READ) begin
         reply_byte = in_array ? flash_image[addr] : ERASED_BYTE;
         // any read ends a pending command; autoselect answers ids on three keys
         if (cmd_state != CMD_IDLE) begin
            id_key    = {cmd_state[7:4], addr[7:0]};
            cmd_state = CMD_IDLE;
            if (id_key == KEY_MFR)
               reply_byte = ID_MFR;
            else if (id_key == KEY_DEVICE)
               reply_byte = ID_DEVICE;
            else if (id_key == KEY_PROT)
               reply_byte = ID_PROT;
         end
      end else begin
         // a write in autoselect leaves it and is decoded as from idle
         if (cmd_state[7:4] == CMD_HI_AUTOSEL)
            cmd_state = CMD_AUTOSEL;
         case (cmd_state[3:0])
            STEP_IDLE: begin
               // reset, suspend and sector-erase bytes are no-ops here
               cmd_state = CMD_IDLE;
               if (low_addr == UNLOCK_ADDR1 && data == DATA_UNLOCK1)
                  cmd_state = CMD_UNLOCK1;
            end
            STEP_UNLOCK1: begin
               if (low_addr == UNLOCK_ADDR2 && data == DATA_UNLOCK2)
                  cmd_state = CMD_UNLOCK2;
               else
                  cmd_state = CMD_IDLE;
            end
            STEP_UNLOCK2: begin
               if (low_addr == UNLOCK_ADDR1 && (data == DATA_ERASE ||
                   data == DATA_AUTOSEL || data == DATA_PROGRAM))
                  cmd_state = {data[7:4], STEP_SELECT};
               else
                  cmd_state = CMD_IDLE;
            end
            STEP_SELECT: begin
               if (cmd_state[7:4] == CMD_HI_PROGRAM) begin
                  // program can only clear bits
                  if (!protect_on && in_array) begin
                     programmed = data & flash_image[addr];
                     if (programmed != flash_image[addr]) begin
                        image_changed     = 1'b1;
                        image_erased      = 1'b0;
                        flash_image[addr] = programmed;
                     end
                  end
                  cmd_state = CMD_IDLE;
               end else if (low_addr == UNLOCK_ADDR1 && data == DATA_UNLOCK1) begin
                  cmd_state = cmd_state + 8'd1;
               end else begin
                  cmd_state = CMD_IDLE;
               end
            end
            STEP_UNLOCK3: begin
               if (low_addr == UNLOCK_ADDR2 && data == DATA_UNLOCK2)
                  cmd_state = cmd_state + 8'd1;
               else
                  cmd_state = CMD_IDLE;
            end
            STEP_CONFIRM: begin
               // chip and sector erase both clear the whole array
               if ((low_addr == UNLOCK_ADDR1 && data == DATA_CHIP_ERASE) ||
                   data == DATA_SECT_ERASE) begin
                  if (!(protect_on || image_erased)) begin
                     image_changed = 1'b1;
                     image_erased  = 1'b1;
                     foreach (flash_image[i])
                        flash_image[i] = ERASED_BYTE;
                  end
               end
               cmd_state = CMD_IDLE;
            end
            default: cmd_state = CMD_IDLE;
         endcase
      end
   endtask

   function automatic logic confirms_erase(input logic [15:0] addr, input logic [7:0] data);
      return cmd_state[3:0] == STEP_CONFIRM &&
             ((addr[13:0] == UNLOCK_ADDR1 && data == DATA_CHIP_ERASE) ||
              data == DATA_SECT_ERASE);
   endfunction

   // one request transfer, with sender gaps; predicts its reply on acceptance
   task automatic send_access(input logic kind, input logic [15:0] addr,
                              input logic [7:0] data);
      logic [7:0]      reply_byte;
      flash_reply_type reply;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      // each erase sweeps the whole array, so only a few are let through
      if (kind == KIND_WRITE && confirms_erase(addr, data)) begin
         if (erase_allowance == 0)
            data = data ^ 8'h01;
         else
            erase_allowance--;
      end
      req_valid      = 1'b1;
      req_kind       = kind;
      req_address    = addr;
      req_write_data = data;
      do
         @(posedge clock);
      while (req_stall);
      emulate_access(kind, addr, data, reply_byte);
      reply.read_data = reply_byte;
      reply.modified  = image_changed;
      awaited_replies.push_back(reply);
      items_sent++;
   endtask

   task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
      send_access(KIND_WRITE, addr, data);
   endtask

   task automatic send_read(input logic [15:0] addr);
      send_access(KIND_READ, addr, 8'($urandom));
   endtask

   // hold the request side quiet until every reply has come back
   task automatic wait_for_replies();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_replies.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_write_protect(input logic value);
      wait_for_replies();
      repeat (8) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(posedge clock);
      protect_on = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // unlock address with random bits above the compared 14
   function automatic logic [15:0] alias_of(input logic [13:0] base);
      return {2'($urandom_range(3)), base};
   endfunction

   function automatic logic [15:0] pick_address();
      if ($urandom_range(9) < 6)
         return address_pool[$urandom_range(POOL_SIZE - 1)];
      return 16'($urandom);
   endfunction

   task automatic send_unlock();
      send_write(alias_of(UNLOCK_ADDR1), DATA_UNLOCK1);
      send_write(alias_of(UNLOCK_ADDR2), DATA_UNLOCK2);
   endtask

   task automatic program_sequence();
      logic [15:0] target;
      target = pick_address();
      send_unlock();
      send_write(alias_of(UNLOCK_ADDR1), DATA_PROGRAM);
      send_write(target, 8'($urandom));
      if ($urandom_range(1))
         send_read(target);
   endtask

   task automatic autoselect_sequence();
      logic [7:0] low_byte;
      send_unlock();
      send_write(alias_of(UNLOCK_ADDR1), DATA_AUTOSEL);
      case ($urandom_range(3))
         0: low_byte = KEY_MFR[7:0];
         1: low_byte = KEY_DEVICE[7:0];
         2: low_byte = KEY_PROT[7:0];
         default: low_byte = 8'($urandom);
      endcase
      case ($urandom_range(9))
         7: send_write(alias_of(UNLOCK_ADDR1), DATA_UNLOCK1);
         8: send_write(16'($urandom), 8'($urandom));
         9: ;
         default: send_read({8'($urandom), low_byte});
      endcase
   endtask

   task automatic erase_sequence();
      send_unlock();
      send_write(alias_of(UNLOCK_ADDR1), DATA_ERASE);
      send_unlock();
      case ($urandom_range(4))
         0, 1: send_write(alias_of(UNLOCK_ADDR1), DATA_CHIP_ERASE);
         2: send_write(16'($urandom), DATA_SECT_ERASE);
         3: send_write(16'($urandom), DATA_CHIP_ERASE);
         default: send_write(16'($urandom), 8'($urandom));
      endcase
   endtask

   // a valid prefix cut off by a read, a stray write or a near-miss unlock
   task automatic broken_sequence();
      int         depth;
      logic [7:0] select_code;
      depth       = $urandom_range(5, 1);
      select_code = DATA_ERASE;
      if (depth >= 3 && $urandom_range(1)) begin
         select_code = $urandom_range(1) ? DATA_PROGRAM : DATA_AUTOSEL;
         depth       = 3;
      end
      send_write(alias_of(UNLOCK_ADDR1), DATA_UNLOCK1);
      if (depth >= 2) send_write(alias_of(UNLOCK_ADDR2), DATA_UNLOCK2);
      if (depth >= 3) send_write(alias_of(UNLOCK_ADDR1), select_code);
      if (depth >= 4) send_write(alias_of(UNLOCK_ADDR1), DATA_UNLOCK1);
      if (depth >= 5) send_write(alias_of(UNLOCK_ADDR2), DATA_UNLOCK2);
      case ($urandom_range(2))
         0: send_read(pick_address());
         1: send_write(16'($urandom), 8'($urandom));
         default: send_write(alias_of(UNLOCK_ADDR2 ^ (14'h1 << $urandom_range(13))),
                             DATA_UNLOCK2);
      endcase
   endtask

   task automatic noise_write();
      case ($urandom_range(4))
         0: send_write(16'($urandom), DATA_RESET);
         1: send_write(16'($urandom), DATA_SUSPEND);
         2: send_write(16'($urandom), DATA_SECT_ERASE);
         default: send_write(16'($urandom), 8'($urandom));
      endcase
   endtask

   // random command traffic under one protect setting and one idling mix
   task automatic run_random_phase(input int item_count, input int idle_pct,
                                   input int stall_pct, input logic protect,
                                   input logic drain_pauses);
      int target;
      int pick;
      set_write_protect(protect);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      erase_allowance    = 1;
      target             = items_sent + item_count;
      while (items_sent < target) begin
         if (drain_pauses && $urandom_range(29) == 0)
            wait_for_replies();
         pick = $urandom_range(99);
         if (pick < 30)
            program_sequence();
         else if (pick < 48)
            autoselect_sequence();
         else if (pick < 54)
            erase_sequence();
         else if (pick < 72)
            send_read(pick_address());
         else if (pick < 90)
            broken_sequence();
         else
            noise_write();
      end
      wait_for_replies();
   endtask

   task automatic test_idle_control_bytes();
      send_read(16'h0000);
      send_write(16'h0AAA, DATA_RESET);
      send_write(16'h0AAA, DATA_SUSPEND);
      send_write(16'h0AAA, DATA_SECT_ERASE);
      send_write(16'h0000, 8'hFF);
   endtask

   task automatic test_program_clears_bits();
      send_unlock();
      send_write(16'h0AAA, DATA_PROGRAM);
      send_write(16'hFFFF, 8'h00);
      send_read(16'hFFFF);
   endtask

   task automatic test_autoselect_ids();
      send_unlock();
      send_write(16'h0AAA, DATA_AUTOSEL);
      send_read(16'hFF02);
   endtask

   task automatic test_chip_erase();
      send_unlock();
      send_write(16'h0AAA, DATA_ERASE);
      send_unlock();
      send_write(16'h0AAA, DATA_CHIP_ERASE);
      send_read(16'hFFFF);
   endtask

   task automatic test_erase_of_erased_array();
      send_unlock();
      send_write(16'h0AAA, DATA_ERASE);
      send_unlock();
      send_write(16'h8000, DATA_SECT_ERASE);
   endtask

   task automatic test_write_protect();
      set_write_protect(1'b1);
      send_unlock();
      send_write(16'h0AAA, DATA_PROGRAM);
      send_write(16'h0000, 8'h00);
      send_read(16'h0000);
   endtask

   task automatic test_random_no_idle();
      run_random_phase(340, 0, 0, 1'b0, 1'b0);
   endtask

   task automatic test_random_sender_gaps();
      run_random_phase(340, 68, 0, 1'b1, 1'b0);
   endtask

   task automatic test_random_receiver_stalls();
      run_random_phase(340, 0, 68, 1'b0, 1'b0);
   endtask

   task automatic test_random_both_idle();
      run_random_phase(340, 32, 32, 1'b1, 1'b0);
   endtask

   task automatic test_random_drained_bursts();
      run_random_phase(340, 32, 32, 1'b0, 1'b1);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_kind           = KIND_READ;
      req_address        = '0;
      req_write_data     = 8'h00;
      rsp_stall          = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      erase_allowance    = 2;
      items_sent         = 0;
      mismatch_count     = 0;
      cycle_count        = 0;
      cmd_state          = CMD_IDLE;
      image_erased       = 1'b1;
      image_changed      = 1'b0;
      protect_on         = 1'b0;
      foreach (flash_image[i])
         flash_image[i] = ERASED_BYTE;
      foreach (address_pool[i])
         address_pool[i] = 16'($urandom);
      address_pool[0] = 16'h0000;
      address_pool[1] = 16'hFFFF;
      address_pool[2] = 16'h0AAA;
      address_pool[3] = 16'h0555;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_control_bytes();
      test_program_clears_bits();
      test_autoselect_ids();
      test_chip_erase();
      test_erase_of_erased_array();
      test_write_protect();
      test_random_no_idle();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_both_idle();
      test_random_drained_bursts();

      wait_for_replies();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
